>>> design/pba_pkg.sv
// shared constants and control/status types for the paged bump allocator
package pba_pkg;

	// allocation geometry
	localparam int unsigned PAGE_BYTES  = 65536;
	localparam int unsigned MAX_PAGES   = 16;
	localparam int unsigned ALIGN_BYTES = 256;

	// derived widths
	localparam int unsigned ALIGN_W    = $clog2(ALIGN_BYTES);
	localparam int unsigned PAGE_UNITS = PAGE_BYTES / ALIGN_BYTES;
	localparam int unsigned FILL_W     = $clog2(PAGE_UNITS + 1);
	localparam int unsigned IDX_W      = $clog2(MAX_PAGES);
	localparam int unsigned CNT_W      = $clog2(MAX_PAGES + 1);

	// field widths
	localparam int unsigned SIZE_W   = 24;
	localparam int unsigned CLASS_W  = 3;
	localparam int unsigned BUFNUM_W = 16;
	localparam int unsigned PAGE_W   = 4;
	localparam int unsigned OFFS_W   = 16;
	localparam int unsigned ROUND_W  = 17;
	localparam int unsigned UNITS_W  = SIZE_W - ALIGN_W + 1;

	// controller to datapath commands
	typedef struct packed {
		logic load;      // capture a new request, restart the scan
		logic step;      // move to the next page
		logic fin_hit;   // allocate in the page under the scan index
		logic fin_open;  // open a new page, or refuse if the table is full
		logic fin_err;   // refuse an oversize request
	} pba_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic oversize;  // rounded size exceeds a page
		logic hit;       // page under the scan index fits the request
		logic scan_end;  // scan index has passed the last open page
	} pba_sts_t;

endpackage

>>> design/pba_ctrl.sv
// controller state machine: request intake, page scan sequencing, result slot
module pba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  pba_pkg::pba_sts_t sts,
	output pba_pkg::pba_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;
	logic   out_set;
	logic   slot_free;

	assign slot_free = !out_valid_q || m_tready;

	// next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		out_set = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!sts.oversize && !sts.hit && !sts.scan_end) begin
					cmd.step = 1'b1;
				end else if (slot_free) begin
					if (sts.oversize) begin
						cmd.fin_err = 1'b1;
					end else if (sts.hit) begin
						cmd.fin_hit = 1'b1;
					end else begin
						cmd.fin_open = 1'b1;
					end
					out_set = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// result slot occupancy
	always_comb begin
		if (out_set) begin
			out_valid_d = 1'b1;
		end else if (m_tready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

endmodule

>>> design/pba_dpath.sv
// datapath: size rounding, page table, scan index, counters and result register
module pba_dpath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [pba_pkg::SIZE_W-1:0]       size_bytes,
	input  logic [pba_pkg::CLASS_W-1:0]      state_class,
	input  pba_pkg::pba_cmd_t                cmd,
	output pba_pkg::pba_sts_t                sts,
	output logic [pba_pkg::BUFNUM_W-1:0]     buffer_number,
	output logic [pba_pkg::PAGE_W-1:0]       page_number,
	output logic [pba_pkg::OFFS_W-1:0]       byte_offset,
	output logic [pba_pkg::ROUND_W-1:0]      rounded_size,
	output logic                             opened_page,
	output logic                             alloc_error
);

	// page table, valid only below pages_open_q
	logic [pba_pkg::CLASS_W-1:0] page_class_q [pba_pkg::MAX_PAGES];
	logic [pba_pkg::FILL_W-1:0]  page_fill_q  [pba_pkg::MAX_PAGES];

	logic [pba_pkg::CNT_W-1:0]    pages_open_q;
	logic [pba_pkg::BUFNUM_W-1:0] next_buffer_q;
	logic [pba_pkg::CNT_W-1:0]    idx_q;

	// captured request
	logic                         oversize_q;
	logic [pba_pkg::FILL_W-1:0]   units_q;
	logic [pba_pkg::CLASS_W-1:0]  class_q;

	// result register
	logic [pba_pkg::BUFNUM_W-1:0] res_buf_q;
	logic [pba_pkg::PAGE_W-1:0]   res_page_q;
	logic [pba_pkg::OFFS_W-1:0]   res_offs_q;
	logic [pba_pkg::ROUND_W-1:0]  res_round_q;
	logic                         res_open_q;
	logic                         res_err_q;

	logic [pba_pkg::UNITS_W-1:0]  units_in;
	logic [pba_pkg::IDX_W-1:0]    idx;
	logic [pba_pkg::IDX_W-1:0]    new_idx;
	logic [pba_pkg::FILL_W-1:0]   cur_fill;
	logic [pba_pkg::FILL_W:0]     fill_sum;
	logic                         table_full;

	// size in alignment units, rounded up
	assign units_in = pba_pkg::UNITS_W'(size_bytes[pba_pkg::SIZE_W-1:pba_pkg::ALIGN_W])
		+ pba_pkg::UNITS_W'(|size_bytes[pba_pkg::ALIGN_W-1:0]);

	// fit test on the page under the scan index
	assign idx        = idx_q[pba_pkg::IDX_W-1:0];
	assign new_idx    = pages_open_q[pba_pkg::IDX_W-1:0];
	assign cur_fill   = page_fill_q[idx];
	assign fill_sum   = {1'b0, cur_fill} + {1'b0, units_q};
	assign table_full = (pages_open_q == pba_pkg::CNT_W'(pba_pkg::MAX_PAGES));

	assign sts.oversize = oversize_q;
	assign sts.scan_end = (idx_q >= pages_open_q);
	assign sts.hit      = (idx_q < pages_open_q) && (page_class_q[idx] == class_q)
		&& (cur_fill < pba_pkg::FILL_W'(pba_pkg::PAGE_UNITS))
		&& (fill_sum <= (pba_pkg::FILL_W + 1)'(pba_pkg::PAGE_UNITS));

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			oversize_q <= (units_in > pba_pkg::UNITS_W'(pba_pkg::PAGE_UNITS));
			units_q    <= units_in[pba_pkg::FILL_W-1:0];
			class_q    <= state_class;
		end
	end

	// scan index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load) begin
			idx_q <= '0;
		end else if (cmd.step) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// page table writes
	always_ff @(posedge clk) begin
		if (cmd.fin_hit) begin
			page_fill_q[idx] <= fill_sum[pba_pkg::FILL_W-1:0];
		end else if (cmd.fin_open && !table_full) begin
			page_class_q[new_idx] <= class_q;
			page_fill_q[new_idx]  <= units_q;
		end
	end

	// open page count and running buffer number
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pages_open_q  <= '0;
			next_buffer_q <= '0;
		end else begin
			if (cmd.fin_open && !table_full) begin
				pages_open_q <= pages_open_q + 1'b1;
			end
			if (cmd.fin_hit || (cmd.fin_open && !table_full)) begin
				next_buffer_q <= next_buffer_q + 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.fin_err || (cmd.fin_open && table_full)) begin
			res_buf_q   <= '0;
			res_page_q  <= '0;
			res_offs_q  <= '0;
			res_round_q <= '0;
			res_open_q  <= 1'b0;
			res_err_q   <= 1'b1;
		end else if (cmd.fin_hit) begin
			res_buf_q   <= next_buffer_q;
			res_page_q  <= pba_pkg::PAGE_W'(idx);
			res_offs_q  <= pba_pkg::OFFS_W'({cur_fill, pba_pkg::ALIGN_W'(0)});
			res_round_q <= pba_pkg::ROUND_W'({units_q, pba_pkg::ALIGN_W'(0)});
			res_open_q  <= 1'b0;
			res_err_q   <= 1'b0;
		end else if (cmd.fin_open) begin
			res_buf_q   <= next_buffer_q;
			res_page_q  <= pba_pkg::PAGE_W'(new_idx);
			res_offs_q  <= '0;
			res_round_q <= pba_pkg::ROUND_W'({units_q, pba_pkg::ALIGN_W'(0)});
			res_open_q  <= 1'b1;
			res_err_q   <= 1'b0;
		end
	end

	assign buffer_number = res_buf_q;
	assign page_number   = res_page_q;
	assign byte_offset   = res_offs_q;
	assign rounded_size  = res_round_q;
	assign opened_page   = res_open_q;
	assign alloc_error   = res_err_q;

endmodule

>>> design/paged_bump_allocator.sv
// top level of the first-fit paged bump allocator
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+-----------------------------------------------
//  s_      | in  | s_tvalid/s_tready | s_tdata: size_bytes[23:0], state_class[26:24]
//  m_      | out | m_tvalid/m_tready | m_tdata: buffer/page/offset/rounded, m_tuser: flags
//
// a request passes from its transfer through a scan of the open pages to the result
// register, the scan moving one page per cycle over the page table up to the first fit
// (at most 16 pages scanned); an oversize request finishes without a scan
// reset empties the page table and clears the buffer number; no clearing pass
// the next request is taken while a result still waits; the scan holds at its end
// until the result register is free
module paged_bump_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // size_bytes[23:0], state_class[26:24], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // buffer_number[15:0], page_number[19:16],
	                               // byte_offset[35:20], rounded_size[52:36], zero pad
	output logic [1:0]  m_tuser    // opened_page[0], alloc_error[1]
);

	pba_pkg::pba_cmd_t cmd;
	pba_pkg::pba_sts_t sts;

	logic [pba_pkg::BUFNUM_W-1:0] buffer_number;
	logic [pba_pkg::PAGE_W-1:0]   page_number;
	logic [pba_pkg::OFFS_W-1:0]   byte_offset;
	logic [pba_pkg::ROUND_W-1:0]  rounded_size;
	logic                         opened_page;
	logic                         alloc_error;

	pba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pba_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.size_bytes    (s_tdata[23:0]),
		.state_class   (s_tdata[26:24]),
		.cmd           (cmd),
		.sts           (sts),
		.buffer_number (buffer_number),
		.page_number   (page_number),
		.byte_offset   (byte_offset),
		.rounded_size  (rounded_size),
		.opened_page   (opened_page),
		.alloc_error   (alloc_error)
	);

	// result packing
	assign m_tdata = {3'b000, rounded_size, byte_offset, page_number, buffer_number};
	assign m_tuser = {alloc_error, opened_page};

endmodule

>>> design/pba_checker.sv
// port-level checker for the paged bump allocator, bound to the top level
module pba_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// a request transfer closes the input while its scan runs
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while a scan was running");

	// a refused request carries no allocation
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> (m_tdata == 56'd0) && !m_tuser[0])
		else $error("refused request with nonzero result");

	// a freshly opened page starts at offset zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata[35:20] == 16'd0))
		else $error("opened page with nonzero offset");

	// the rounded size stays aligned and the allocation stays inside its page
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[43:36] == 8'd0)
			&& (({1'b0, m_tdata[35:20]} + {1'b0, m_tdata[52:36]}) <= 18'd65536))
		else $error("allocation misaligned or beyond page end");

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

endmodule

bind paged_bump_allocator pba_checker u_pba_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

>>> bench/tb_paged_bump_allocator.sv
// self-checking testbench for the paged bump allocator: directed table, then random requests
`timescale 1ns / 100ps

module tb_paged_bump_allocator;

	// one allocation grant as it leaves the block
	typedef struct packed {
		logic [pba_pkg::BUFNUM_W-1:0] buf_no;
		logic [pba_pkg::PAGE_W-1:0]   page;
		logic [pba_pkg::OFFS_W-1:0]   offset;
		logic [pba_pkg::ROUND_W-1:0]  rounded;
		logic                         opened;
		logic                         refused;
	} grant_t;

	// one row of the directed table; want is used only when typed is set
	typedef struct packed {
		logic [pba_pkg::SIZE_W-1:0]  size;
		logic [pba_pkg::CLASS_W-1:0] cls;
		logic                        typed;
		grant_t                      want;
	} probe_t;

	localparam grant_t NO_GRANT = '0;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic [1:0]  m_tuser;

	// page table mirror for the predictor
	logic [pba_pkg::CLASS_W-1:0]  pg_class [pba_pkg::MAX_PAGES];
	logic [pba_pkg::ROUND_W-1:0]  pg_fill [pba_pkg::MAX_PAGES];
	logic [pba_pkg::CNT_W-1:0]    pages_used = '0;
	logic [pba_pkg::BUFNUM_W-1:0] next_buf_no = '0;

	grant_t      grants_due [$];
	probe_t      rows [$];
	int unsigned faults = 0;
	bit          calm = 1'b0;
	int unsigned stall_left = 0;

	paged_bump_allocator u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #10 clk = ~clk;

	// first-fit placement over the mirrored page table
	function automatic grant_t predict_grant(input logic [pba_pkg::SIZE_W-1:0] sz,
	                                         input logic [pba_pkg::CLASS_W-1:0] cl);
		grant_t      g;
		int unsigned rnd;
		int unsigned fill;
		bit          hit;
		g = '0;
		hit = 1'b0;
		rnd = ((32'(sz) + pba_pkg::ALIGN_BYTES - 1) / pba_pkg::ALIGN_BYTES)
			* pba_pkg::ALIGN_BYTES;
		if (rnd > pba_pkg::PAGE_BYTES) begin
			g.refused = 1'b1;
			return g;
		end
		for (int i = 0; i < int'(pages_used) && !hit; i++) begin
			fill = 32'(pg_fill[i]);
			// a full page never takes even a zero-size request
			if (pg_class[i] == cl && fill < pba_pkg::PAGE_BYTES
				&& fill <= pba_pkg::PAGE_BYTES - rnd) begin
				hit = 1'b1;
				g.page = pba_pkg::PAGE_W'(i);
				g.offset = pba_pkg::OFFS_W'(fill);
				pg_fill[i] = pba_pkg::ROUND_W'(fill + rnd);
			end
		end
		if (!hit) begin
			// table full is refused like an oversize request
			if (pages_used == pba_pkg::CNT_W'(pba_pkg::MAX_PAGES)) begin
				g.refused = 1'b1;
				return g;
			end
			g.page = pages_used[pba_pkg::PAGE_W-1:0];
			pg_class[pages_used[pba_pkg::PAGE_W-1:0]] = cl;
			pg_fill[pages_used[pba_pkg::PAGE_W-1:0]] = pba_pkg::ROUND_W'(rnd);
			pages_used = pages_used + 1'b1;
			g.opened = 1'b1;
		end
		g.buf_no = next_buf_no;
		g.rounded = pba_pkg::ROUND_W'(rnd);
		next_buf_no = next_buf_no + 1'b1;
		return g;
	endfunction

	// idle length: mostly none or short, a few long, none in calm stretches
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d got %0d", $time, what, want, got);
			faults++;
		end
	endtask

	// one request transfer, then its expectation and an optional gap
	task automatic send(input logic [pba_pkg::SIZE_W-1:0] sz,
	                    input logic [pba_pkg::CLASS_W-1:0] cl,
	                    input logic typed, input grant_t want);
		grant_t      g;
		int unsigned gap;
		s_tdata <= {5'b0, cl, sz};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		g = predict_grant(sz, cl);
		grants_due.push_back(typed ? want : g);
		gap = pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// result checking and receiver stalls
	always @(posedge clk) begin : rx
		grant_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (grants_due.size() == 0) begin
				$display("%0t: unexpected result tdata %h tuser %b", $time, m_tdata, m_tuser);
				faults++;
			end else begin
				want = grants_due.pop_front();
				check_field("buffer_number", 32'(want.buf_no), 32'(m_tdata[15:0]));
				check_field("page_number", 32'(want.page), 32'(m_tdata[19:16]));
				check_field("byte_offset", 32'(want.offset), 32'(m_tdata[35:20]));
				check_field("rounded_size", 32'(want.rounded), 32'(m_tdata[52:36]));
				check_field("opened_page", 32'(want.opened), 32'(m_tuser[0]));
				check_field("alloc_error", 32'(want.refused), 32'(m_tuser[1]));
			end
		end
		if (stall_left != 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 99) < 30)
				stall_left = pick_gap();
		end
	end

	// stimulus and end of run
	initial begin : stim
		logic [pba_pkg::SIZE_W-1:0]  sz;
		logic [pba_pkg::CLASS_W-1:0] cl;
		int unsigned                 r;

		// empty table: zero size opens page 0
		rows.push_back('{24'd0, 3'd0, 1'b1, '{16'd0, 4'd0, 16'd0, 17'd0, 1'b1, 1'b0}});
		// oversize, largest field value and just over a page
		rows.push_back('{24'hFFFFFF, 3'd7, 1'b1, '{16'd0, 4'd0, 16'd0, 17'd0, 1'b0, 1'b1}});
		rows.push_back('{24'h010001, 3'd3, 1'b1, '{16'd0, 4'd0, 16'd0, 17'd0, 1'b0, 1'b1}});
		// exact page fits the empty page 0
		rows.push_back('{24'h010000, 3'd0, 1'b1, '{16'd1, 4'd0, 16'd0, 17'h10000, 1'b0, 1'b0}});
		// zero size skips the full page and opens page 1
		rows.push_back('{24'd0, 3'd0, 1'b1, '{16'd2, 4'd1, 16'd0, 17'd0, 1'b1, 1'b0}});
		rows.push_back('{24'd1, 3'd5, 1'b1, '{16'd3, 4'd2, 16'd0, 17'd256, 1'b1, 1'b0}});
		// rounding edges and filling a page to the last byte
		rows.push_back('{24'd256, 3'd5, 1'b0, NO_GRANT});
		rows.push_back('{24'd257, 3'd5, 1'b0, NO_GRANT});
		rows.push_back('{24'd65280, 3'd0, 1'b0, NO_GRANT});
		rows.push_back('{24'd255, 3'd0, 1'b0, NO_GRANT});
		rows.push_back('{24'd65535, 3'd1, 1'b0, NO_GRANT});
		rows.push_back('{24'h00FF00, 3'd2, 1'b0, NO_GRANT});
		rows.push_back('{24'h000100, 3'd2, 1'b0, NO_GRANT});
		rows.push_back('{24'd0, 3'd5, 1'b0, NO_GRANT});
		rows.push_back('{24'h00FFFF, 3'd4, 1'b0, NO_GRANT});
		rows.push_back('{24'h0100FF, 3'd6, 1'b1, '{16'd0, 4'd0, 16'd0, 17'd0, 1'b0, 1'b1}});
		rows.push_back('{24'h010000, 3'd7, 1'b0, NO_GRANT});
		rows.push_back('{24'h800000, 3'd1, 1'b1, '{16'd0, 4'd0, 16'd0, 17'd0, 1'b0, 1'b1}});
		rows.push_back('{24'h00AAAA, 3'd3, 1'b0, NO_GRANT});
		rows.push_back('{24'h005555, 3'd3, 1'b0, NO_GRANT});
		rows.push_back('{24'd0, 3'd6, 1'b0, NO_GRANT});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (rows[k])
			send(rows[k].size, rows[k].cls, rows[k].typed, rows[k].want);

		// random requests; the page table fills up along the way
		for (int n = 0; n < 1030; n++) begin
			if (n % 64 == 0)
				calm = ($urandom_range(0, 3) == 0);
			// let the block drain completely once
			if (n == 500) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (grants_due.size() != 0) @(posedge clk);
			end
			r = $urandom_range(0, 99);
			if (r < 60)
				sz = pba_pkg::SIZE_W'($urandom_range(0, 1023));
			else if (r < 75)
				sz = pba_pkg::SIZE_W'($urandom_range(1024, 8191));
			else if (r < 80)
				sz = pba_pkg::SIZE_W'($urandom_range(8192, 65536));
			else if (r < 88)
				sz = pba_pkg::SIZE_W'($urandom_range(65537, 24'hFFFFFF));
			else if (r < 93)
				sz = '0;
			else if (r < 96)
				sz = 24'h010000;
			else
				sz = pba_pkg::SIZE_W'($urandom_range(1, 256) * pba_pkg::ALIGN_BYTES);
			cl = pba_pkg::CLASS_W'($urandom_range(0, 7));
			send(sz, cl, 1'b0, NO_GRANT);
		end
		s_tvalid <= 1'b0;
		calm = 1'b0;

		while (grants_due.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (faults == 0)
			$display("paged_bump_allocator test passed");
		else
			$display("paged_bump_allocator test failed");
		$finish;
	end

	// watchdog
	initial begin
		#25_000_000;
		$display("paged_bump_allocator test failed");
		$finish;
	end

endmodule
